[sv/assert_macros.svh]
// Assertion macros for the RTL of the motion sensor block.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside of reset.
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/pwdc_pkg.sv]
// Package of the motion sensor warm-up and debounce block: state encoding,
// status codes, register map, reset values and the ms-to-seconds helper. No dependencies.
package pwdc_pkg;

  localparam int unsigned WARMUP_W   = 17;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned CONFIRM_W  = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned LEFT_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_WARMUP   = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_CONFIRM  = 2'd3;

  localparam logic [WARMUP_W-1:0]   RST_WARMUP   = 17'd60000;
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 10'd100;
  localparam logic [CONFIRM_W-1:0]  RST_CONFIRM  = 4'd3;

  // status codes on the result beat
  localparam logic [STATUS_W-1:0] ST_UNINIT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WARM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_READY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd3;

  // x / 1000 as x * ceil(2^27 / 1000) >> 27, exact for x < 2^17
  localparam int unsigned        RECIP_SHIFT = 27;
  localparam int unsigned        RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 18'd134218;
  localparam int unsigned        PROD_W      = WARMUP_W + RECIP_W;

  typedef enum logic [3:0] {
    MODE_UNINIT   = 4'b0001,
    MODE_WARM     = 4'b0010,
    MODE_READY    = 4'b0100,
    MODE_DISABLED = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] sensor_status;
    logic                motion;
    logic [COUNT_W-1:0]  motion_tally;
    logic                motion_rise;
    logic [LEFT_W-1:0]   warmup_left_s;
  } result_t;

  function automatic logic [LEFT_W-1:0] ms_to_s(input logic [WARMUP_W-1:0] ms);
    logic [PROD_W-1:0] prod;
    prod = {{RECIP_W{1'b0}}, ms} * {{WARMUP_W{1'b0}}, RECIP_1000};
    return prod[RECIP_SHIFT +: LEFT_W];
  endfunction

  function automatic logic [STATUS_W-1:0] mode_status(input mode_t m);
    logic [STATUS_W-1:0] st;
    unique case (m)
      MODE_UNINIT:   st = ST_UNINIT;
      MODE_WARM:     st = ST_WARM;
      MODE_READY:    st = ST_READY;
      MODE_DISABLED: st = ST_DISABLED;
      default:       st = ST_UNINIT;
    endcase
    return st;
  endfunction

endpackage

[sv/pir_warmup_debounce_counter_unit.sv]
// Motion sensor warm-up and debounce counter: top level, single module.
// Depends on pwdc_pkg and assert_macros.svh.
//
// Usage: every input beat is one millisecond tick with the raw sensor pin
// level on pin_level; every tick yields exactly one result beat with status,
// debounced motion, rise count, rise pulse and remaining warm-up seconds.
// Both channels are valid/stall; a beat moves when valid is high and stall low.
// The first tick after reset starts warm-up (or disables the sensor when
// sensor_enable is 0). Registers sit on an APB-style port at 4*index; the
// user must write them only while no ticks are in flight; the block does not
// enforce this. The result is registered. Throughput: one tick per cycle
// while in_stall is low; the state update and the /1000 (a constant
// multiply) are combinational between the state registers and the result
// register. The result register is backed by a one-beat skid, so a stalled
// receiver does not hold up the input until both hold a beat; in_stall
// then rises and stays up until the receiver takes one. Reset clears the
// state, config registers to defaults, both valid flags; no clearing pass.
module pir_warmup_debounce_counter_unit (
  input  logic                         clk,
  input  logic                         rst,
  // tick input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         pin_level,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pwdc_pkg::STATUS_W-1:0] sensor_status,
  output logic                         motion,
  output logic [pwdc_pkg::COUNT_W-1:0]  motion_tally,
  output logic                         motion_rise,
  output logic [pwdc_pkg::LEFT_W-1:0]   warmup_left_s,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pwdc_pkg::DATA_W-1:0]   pwdata,
  output logic [pwdc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pwdc_pkg::*;
  `include "assert_macros.svh"

  // config registers
  logic                  sensor_enable;
  logic [WARMUP_W-1:0]   warmup_ms;
  logic [INTERVAL_W-1:0] sample_interval_ms;
  logic [CONFIRM_W-1:0]  confirm_count;
  logic                  cfg_wr;
  logic [1:0]            cfg_idx;

  // block state
  mode_t                 mode, mode_next;
  logic [WARMUP_W-1:0]   warmup_elapsed, warmup_elapsed_next;
  logic [INTERVAL_W-1:0] since_sample, since_sample_next;
  logic [CONFIRM_W-1:0]  differ_run, differ_run_next;
  logic                  debounced_level, debounced_level_next;
  logic [COUNT_W-1:0]    rise_total, rise_total_next;
  logic                  first_sample_due, first_sample_due_next;

  // result slots
  result_t               res, out_q, skid_q;
  logic                  skid_valid;

  logic                  push, pop;
  logic                  rise;
  logic [WARMUP_W:0]     warm_inc;
  logic [INTERVAL_W:0]   since_inc;
  logic [CONFIRM_W:0]    run_inc;
  logic [WARMUP_W-1:0]   left_ms;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, sensor_enable};
      REG_WARMUP:   prdata = {{(DATA_W-WARMUP_W){1'b0}}, warmup_ms};
      REG_INTERVAL: prdata = {{(DATA_W-INTERVAL_W){1'b0}}, sample_interval_ms};
      REG_CONFIRM:  prdata = {{(DATA_W-CONFIRM_W){1'b0}}, confirm_count};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enable      <= 1'b1;
      warmup_ms          <= RST_WARMUP;
      sample_interval_ms <= RST_INTERVAL;
      confirm_count      <= RST_CONFIRM;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:   sensor_enable      <= pwdata[0];
        REG_WARMUP:   warmup_ms          <= pwdata[WARMUP_W-1:0];
        REG_INTERVAL: sample_interval_ms <= pwdata[INTERVAL_W-1:0];
        REG_CONFIRM:  confirm_count      <= pwdata[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state for one tick
  always_comb begin
    mode_next             = mode;
    warmup_elapsed_next   = warmup_elapsed;
    since_sample_next     = since_sample;
    differ_run_next       = differ_run;
    debounced_level_next  = debounced_level;
    rise_total_next       = rise_total;
    first_sample_due_next = first_sample_due;
    rise                  = 1'b0;
    warm_inc  = {1'b0, warmup_elapsed} + 1'b1;
    since_inc = {1'b0, since_sample} + 1'b1;
    run_inc   = {1'b0, differ_run} + 1'b1;

    unique case (mode)
      MODE_UNINIT: begin
        if (sensor_enable) begin
          mode_next           = MODE_WARM;
          warmup_elapsed_next = '0;
        end else begin
          mode_next = MODE_DISABLED;
        end
      end
      MODE_WARM: begin
        if (warm_inc > {1'b0, warmup_ms}) begin
          mode_next             = MODE_READY;
          since_sample_next     = '0;
          first_sample_due_next = 1'b1;
        end else begin
          warmup_elapsed_next = warm_inc[WARMUP_W-1:0];
        end
      end
      MODE_READY: begin
        if (first_sample_due || since_inc > {1'b0, sample_interval_ms}) begin
          first_sample_due_next = 1'b0;
          since_sample_next     = '0;
          if (pin_level != debounced_level) begin
            if (run_inc > {1'b0, confirm_count}) begin
              // run of differing samples long enough: adopt the level
              debounced_level_next = pin_level;
              differ_run_next      = '0;
              if (pin_level) begin
                rise_total_next = rise_total + 1'b1;
                rise            = 1'b1;
              end
            end else begin
              differ_run_next = run_inc[CONFIRM_W-1:0];
            end
          end else begin
            differ_run_next = '0;
          end
        end else begin
          since_sample_next = since_inc[INTERVAL_W-1:0];
        end
      end
      MODE_DISABLED: ;
      default: mode_next = MODE_UNINIT;
    endcase

    left_ms = warmup_ms - warmup_elapsed_next;
    res.sensor_status = mode_status(mode_next);
    res.motion        = (mode_next == MODE_READY) && debounced_level_next;
    res.motion_tally  = rise_total_next;
    res.motion_rise   = rise;
    res.warmup_left_s = (mode_next == MODE_WARM && warmup_ms > warmup_elapsed_next) ?
                        ms_to_s(left_ms) : '0;
  end

  assign push     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_UNINIT;
      warmup_elapsed   <= '0;
      since_sample     <= '0;
      differ_run       <= '0;
      debounced_level  <= 1'b0;
      rise_total       <= '0;
      first_sample_due <= 1'b1;
    end else if (push) begin
      mode             <= mode_next;
      warmup_elapsed   <= warmup_elapsed_next;
      since_sample     <= since_sample_next;
      differ_run       <= differ_run_next;
      debounced_level  <= debounced_level_next;
      rise_total       <= rise_total_next;
      first_sample_due <= first_sample_due_next;
    end
  end

  // result register with a one-beat skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_q <= skid_valid ? skid_q : res;
      if (push) begin
        skid_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign sensor_status = out_q.sensor_status;
  assign motion        = out_q.motion;
  assign motion_tally  = out_q.motion_tally;
  assign motion_rise   = out_q.motion_rise;
  assign warmup_left_s = out_q.warmup_left_s;

  `CHK_PROP(a_skid_behind_out, skid_valid |-> out_valid, "skid holds a beat while out is empty")
  `CHK_PROP(a_rise_ready, out_valid && motion_rise |-> motion && sensor_status == ST_READY, "rise")
  `CHK_PROP(a_left_warm, out_valid && warmup_left_s != '0 |-> sensor_status == ST_WARM, "stray left")
  `CHK_PROP(a_count_step, push && !rise |=> rise_total == $past(rise_total), "count moved")
endmodule
